// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers clocked on clk and disabled during rst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define NST_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("neighbor station table assertion failed");
`define NST_ASSERT_NEVER(label, cond) `NST_ASSERT(label, !(cond))
`else
`define NST_ASSERT(label, prop)
`define NST_ASSERT_NEVER(label, cond)
`endif
`endif

// ===== rtl/nst_pkg.sv =====
// ----------------------------------------------------------------------------
// Neighbor station table package
// Word types, entry layout, operation codes and controller command types.
// ----------------------------------------------------------------------------
package nst_pkg;

    localparam logic [1:0] MODE_REGISTER  = 2'd0;
    localparam logic [1:0] MODE_BEST_RSSI = 2'd1;
    localparam logic [1:0] MODE_READ      = 2'd2;

    localparam logic signed [7:0] NO_RSSI = -8'sd128;
    localparam logic [30:0]       MAX_AGE_RESET = 31'd10;

    typedef struct packed {
        logic [1:0]         mode;
        logic [47:0]        mac;
        logic [3:0]         mcs;
        logic signed [7:0]  rssi;
        logic signed [7:0]  snr;
        logic [30:0]        time_s;
        logic [15:0]        length;
        logic [3:0]         entry_index;
    } req_word_t;

    typedef struct packed {
        logic [4:0]         entry_count;
        logic               found;
        logic [3:0]         slot;
        logic signed [7:0]  best_rssi;
        logic [47:0]        out_mac;
        logic [3:0]         out_mcs;
        logic signed [7:0]  out_rssi;
        logic signed [7:0]  out_snr;
        logic [30:0]        out_last_rx;
        logic [31:0]        out_bytes;
        logic [31:0]        out_packets;
    } rsp_word_t;

    typedef struct packed {
        logic [47:0]        mac;
        logic [3:0]         mcs;
        logic signed [7:0]  rssi;
        logic signed [7:0]  snr;
        logic [30:0]        last_rx;
        logic [31:0]        bytes;
        logic [31:0]        packets;
    } entry_t;

    typedef struct packed {
        logic start;
        logic scan;
        logic commit;
        logic load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic scan_done;
    } dp_status_t;

endpackage

// ===== rtl/nst_ctrl.sv =====
// ----------------------------------------------------------------------------
// Neighbor station table controller
// Sequences accept, table scan, write back and result hand-off.
// ----------------------------------------------------------------------------
module nst_ctrl
    import nst_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_stall,
    output logic       rsp_valid,
    input  logic       rsp_stall,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_COMMIT = 2'd2;
    localparam logic [1:0] ST_DONE   = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       rsp_valid_reg;
    logic       rsp_valid_next;

    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = rsp_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        cmd            = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.start  = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (status.scan_done)
                begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT:
            begin
                cmd.commit = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    cmd.load       = 1'b1;
                    rsp_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

endmodule

// ===== rtl/nst_dp.sv =====
// ----------------------------------------------------------------------------
// Neighbor station table datapath
// Entry memory, one-entry-per-cycle scan for match, oldest and best RSSI,
// write back, age limit register and result register.
// ----------------------------------------------------------------------------
module nst_dp
    import nst_pkg::*;
#(
    parameter int MAX_ENTRIES = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  req_word_t   req_word,
    input  ctrl_cmd_t   cmd,
    output dp_status_t  status,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [30:0] cfg_data,
    output rsp_word_t   rsp_word
);

    localparam int IW   = $clog2(MAX_ENTRIES);
    localparam int CW   = $clog2(MAX_ENTRIES + 1);
    localparam int CMPW = (CW > 4) ? CW : 4;

    entry_t entry_mem [MAX_ENTRIES];

    req_word_t         req_reg;
    logic [CW-1:0]     occ_reg;
    logic [CW-1:0]     occ_next;
    logic [CW-1:0]     issue_reg;
    logic [CW-1:0]     issue_next;
    logic              rd_vld_reg;
    logic [IW-1:0]     rd_idx_reg;
    entry_t            rd_data_reg;
    logic              hit_reg;
    logic [IW-1:0]     hit_idx_reg;
    logic [31:0]       hit_bytes_reg;
    logic [31:0]       hit_packets_reg;
    logic [IW-1:0]     old_idx_reg;
    logic [30:0]       old_time_reg;
    logic signed [7:0] best_reg;
    entry_t            cap_reg;
    logic [IW-1:0]     slot_reg;
    logic [IW-1:0]     slot_next;
    logic [30:0]       max_age_reg;
    rsp_word_t         rsp_reg;
    rsp_word_t         rsp_next;

    logic        issue_go;
    logic [31:0] age;
    logic        recent;
    logic        mac_eq;
    logic        is_full;
    logic        mem_we;
    entry_t      wdata;
    logic        read_found;

    assign cfg_ready        = 1'b1;
    assign status.scan_done = (issue_reg == occ_reg) && !rd_vld_reg;
    assign rsp_word         = rsp_reg;

    assign issue_go = cmd.scan && (issue_reg != occ_reg);
    assign age      = {1'b0, req_reg.time_s} - {1'b0, rd_data_reg.last_rx};
    assign recent   = $signed(age) <= $signed({1'b0, max_age_reg});
    assign mac_eq   = (rd_data_reg.mac == req_reg.mac);
    assign is_full  = (occ_reg == CW'(MAX_ENTRIES));
    assign mem_we   = cmd.commit && (req_reg.mode == MODE_REGISTER);
    assign read_found = (CMPW'(req_reg.entry_index) < CMPW'(occ_reg));

    always_comb
    begin
        priority if (hit_reg)
        begin
            slot_next = hit_idx_reg;
        end
        else if (!is_full)
        begin
            slot_next = occ_reg[IW-1:0];
        end
        else
        begin
            slot_next = old_idx_reg;
        end
    end

    always_comb
    begin
        wdata.mac     = req_reg.mac;
        wdata.mcs     = req_reg.mcs;
        wdata.rssi    = req_reg.rssi;
        wdata.snr     = req_reg.snr;
        wdata.last_rx = req_reg.time_s;
        wdata.bytes   = hit_reg ? (hit_bytes_reg + 32'(req_reg.length))
                                : 32'(req_reg.length);
        wdata.packets = hit_reg ? (hit_packets_reg + 32'd1) : 32'd1;
    end

    always_comb
    begin
        occ_next = occ_reg;
        if (mem_we && !hit_reg && !is_full)
        begin
            occ_next = occ_reg + CW'(1);
        end
    end

    always_comb
    begin
        issue_next = issue_reg;
        if (cmd.start)
        begin
            issue_next = '0;
        end
        else if (issue_go)
        begin
            issue_next = issue_reg + CW'(1);
        end
    end

    always_comb
    begin
        rsp_next             = '0;
        rsp_next.entry_count = 5'(occ_reg);
        unique case (req_reg.mode)
            MODE_REGISTER:
            begin
                rsp_next.found = hit_reg;
                rsp_next.slot  = 4'(slot_reg);
            end
            MODE_BEST_RSSI:
            begin
                rsp_next.best_rssi = best_reg;
            end
            MODE_READ:
            begin
                if (read_found)
                begin
                    rsp_next.found       = 1'b1;
                    rsp_next.out_mac     = cap_reg.mac;
                    rsp_next.out_mcs     = cap_reg.mcs;
                    rsp_next.out_rssi    = cap_reg.rssi;
                    rsp_next.out_snr     = cap_reg.snr;
                    rsp_next.out_last_rx = cap_reg.last_rx;
                    rsp_next.out_bytes   = cap_reg.bytes;
                    rsp_next.out_packets = cap_reg.packets;
                end
            end
            default:
            begin
                rsp_next.found = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg     <= '0;
            issue_reg   <= '0;
            rd_vld_reg  <= 1'b0;
            max_age_reg <= MAX_AGE_RESET;
        end
        else
        begin
            occ_reg    <= occ_next;
            issue_reg  <= issue_next;
            rd_vld_reg <= issue_go;
            if (cfg_valid && cfg_ready)
            begin
                max_age_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            entry_mem[slot_next] <= wdata;
        end
        if (issue_go)
        begin
            rd_data_reg <= entry_mem[issue_reg[IW-1:0]];
            rd_idx_reg  <= issue_reg[IW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            req_reg  <= req_word;
            hit_reg  <= 1'b0;
            best_reg <= NO_RSSI;
        end
        else if (rd_vld_reg)
        begin
            if (!hit_reg && mac_eq)
            begin
                hit_reg         <= 1'b1;
                hit_idx_reg     <= rd_idx_reg;
                hit_bytes_reg   <= rd_data_reg.bytes;
                hit_packets_reg <= rd_data_reg.packets;
            end
            if ((rd_idx_reg == '0) || (rd_data_reg.last_rx < old_time_reg))
            begin
                old_idx_reg  <= rd_idx_reg;
                old_time_reg <= rd_data_reg.last_rx;
            end
            if (recent && ($signed(rd_data_reg.rssi) > best_reg))
            begin
                best_reg <= rd_data_reg.rssi;
            end
            if (CMPW'(rd_idx_reg) == CMPW'(req_reg.entry_index))
            begin
                cap_reg <= rd_data_reg;
            end
        end
        if (cmd.commit)
        begin
            slot_reg <= slot_next;
        end
        if (cmd.load)
        begin
            rsp_reg <= rsp_next;
        end
    end

endmodule

// ===== rtl/neighbor_station_table_top.sv =====
// ----------------------------------------------------------------------------
// Neighbor station table
// Table of radio neighbors keyed by MAC with oldest-entry eviction, best
// recent RSSI query and read by slot.
//
//   Channel | Direction | Handshake          | Word
//   req     | in        | req_valid/stall    | req_word_t
//   rsp     | out       | rsp_valid/stall    | rsp_word_t
//   cfg     | in        | cfg_valid/ready    | max_age_s, 31 bits
//
// Each accepted word is handled in order: the scan reads one entry per cycle
// of the occupied entries through the single read port, then the write back
// (register mode only) and the result load follow. The next word is accepted
// only after that load.
// Words are handled one at a time; a new word is accepted while the previous
// result still waits in the output register, and a finished word waits until
// that result is taken.
// Reset empties the table and sets max_age_s to 10.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module neighbor_station_table_top
    import nst_pkg::*;
#(
    parameter int MAX_ENTRIES = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_stall,
    input  req_word_t   req_word,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output rsp_word_t   rsp_word,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [30:0] cfg_data
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    nst_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .status    (status),
        .cmd       (cmd)
    );

    nst_dp #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_word  (req_word),
        .cmd       (cmd),
        .status    (status),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .rsp_word  (rsp_word)
    );

    `NST_ASSERT(a_accept_then_busy, (req_valid && !req_stall) |=> req_stall)
    `NST_ASSERT(a_rsp_from_load, $rose(rsp_valid) |-> $past(cmd.load))
    `NST_ASSERT(a_cmd_exclusive, $onehot0(cmd))
    `NST_ASSERT(a_load_when_free, cmd.load |-> (!rsp_valid || !rsp_stall))

endmodule

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// Neighbor station table testbench
// Drives request words through the stall handshake with random gaps and
// output stalls, keeps its own copy of the station table to predict every
// reply word, and compares each reply field by field. The age limit register
// is rewritten between phases, including its extremes.
// ----------------------------------------------------------------------------
module tb;
    import nst_pkg::*;

    localparam int ENTRIES = 16;
    localparam int POOL = 24;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        req_valid = 1'b0;
    logic        req_stall;
    req_word_t   req_word = '0;
    logic        rsp_valid;
    logic        rsp_stall = 1'b0;
    rsp_word_t   rsp_word;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [30:0] cfg_data = '0;

    neighbor_station_table_top #(
        .MAX_ENTRIES (ENTRIES)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_word  (req_word),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_word  (rsp_word),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    logic [30:0] age_limit = MAX_AGE_RESET;
    logic [4:0]  used = '0;
    entry_t      stations [ENTRIES];

    req_word_t   req_q [$];
    rsp_word_t   reply_q [$];
    int          fails = 0;
    logic        req_taken = 1'b0;
    logic        cfg_taken = 1'b0;
    int          req_gap = 0;
    int          stall_left = 0;
    bit          calm = 1'b0;
    logic [47:0] mac_pool [POOL];
    int          pool_span = 4;
    int          fresh_pct = 1;
    logic [30:0] clock_s = '0;

    initial
    begin
        forever #4 clk = ~clk;
    end

    function automatic rsp_word_t table_apply(input req_word_t w);
        rsp_word_t r;
        int        hit;
        int        s;
        longint    age;
        r = '0;
        hit = -1;
        s = 0;
        case (w.mode)
            MODE_REGISTER:
            begin
                for (int k = 0; k < used; k++)
                    if (hit < 0 && stations[k].mac == w.mac)
                        hit = k;
                if (hit >= 0)
                begin
                    s = hit;
                    stations[s].bytes = stations[s].bytes + 32'(w.length);
                    stations[s].packets = stations[s].packets + 32'd1;
                end
                else
                begin
                    if (used < ENTRIES)
                    begin
                        s = used;
                        used = used + 5'd1;
                    end
                    else
                    begin
                        for (int k = 1; k < ENTRIES; k++)
                            if (stations[k].last_rx < stations[s].last_rx)
                                s = k;
                    end
                    stations[s].mac = w.mac;
                    stations[s].bytes = 32'(w.length);
                    stations[s].packets = 32'd1;
                end
                stations[s].mcs = w.mcs;
                stations[s].rssi = w.rssi;
                stations[s].snr = w.snr;
                stations[s].last_rx = w.time_s;
                r.found = (hit >= 0);
                r.slot = 4'(s);
            end
            MODE_BEST_RSSI:
            begin
                r.best_rssi = NO_RSSI;
                for (int k = 0; k < used; k++)
                begin
                    age = longint'(w.time_s) - longint'(stations[k].last_rx);
                    if (age <= longint'(age_limit) && stations[k].rssi > r.best_rssi)
                        r.best_rssi = stations[k].rssi;
                end
            end
            MODE_READ:
            begin
                if (w.entry_index < used)
                begin
                    r.found = 1'b1;
                    r.out_mac = stations[w.entry_index].mac;
                    r.out_mcs = stations[w.entry_index].mcs;
                    r.out_rssi = stations[w.entry_index].rssi;
                    r.out_snr = stations[w.entry_index].snr;
                    r.out_last_rx = stations[w.entry_index].last_rx;
                    r.out_bytes = stations[w.entry_index].bytes;
                    r.out_packets = stations[w.entry_index].packets;
                end
            end
            default:
            begin
            end
        endcase
        r.entry_count = used;
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [63:0] exp_v,
                                        input logic [63:0] got_v);
        if (exp_v !== got_v)
        begin
            $error("%s: expected %h, got %h", name, exp_v, got_v);
            fails++;
        end
    endfunction

    function automatic int idle_length();
        int pick;
        pick = $urandom_range(0, 99);
        if (calm || pick < 50)
            return 0;
        else if (pick < 88)
            return $urandom_range(1, 3);
        else
            return $urandom_range(6, 40);
    endfunction

    function automatic req_word_t make_word(input logic [1:0] mode, input logic [47:0] mac,
                                            input logic [3:0] mcs, input logic signed [7:0] rssi,
                                            input logic signed [7:0] snr, input logic [30:0] t,
                                            input logic [15:0] len, input logic [3:0] idx);
        req_word_t w;
        w.mode = mode;
        w.mac = mac;
        w.mcs = mcs;
        w.rssi = rssi;
        w.snr = snr;
        w.time_s = t;
        w.length = len;
        w.entry_index = idx;
        return w;
    endfunction

    function automatic req_word_t random_word();
        req_word_t w;
        int        pick;
        pick = $urandom_range(0, 99);
        if (pick < 58)
            w.mode = MODE_REGISTER;
        else if (pick < 73)
            w.mode = MODE_BEST_RSSI;
        else if (pick < 95)
            w.mode = MODE_READ;
        else
            w.mode = MODE_UNUSED;
        if ($urandom_range(0, 99) < fresh_pct)
            w.mac = 48'({$urandom(), $urandom()});
        else
            w.mac = mac_pool[$urandom_range(0, pool_span - 1)];
        w.mcs = 4'($urandom());
        w.rssi = 8'($urandom());
        w.snr = 8'($urandom());
        w.length = 16'($urandom());
        w.entry_index = 4'($urandom());
        pick = $urandom_range(0, 99);
        if (pick >= 45 && pick < 88)
            clock_s = clock_s + 31'($urandom_range(1, 4));
        else if (pick >= 88 && pick < 95)
            clock_s = 31'($urandom());
        w.time_s = clock_s;
        pick = $urandom_range(0, 99);
        if (pick < 3)
            w.time_s = '0;
        else if (pick < 6)
            w.time_s = '1;
        else if (w.mode == MODE_BEST_RSSI && pick < 60)
            w.time_s = clock_s + 31'($urandom_range(0, 20));
        return w;
    endfunction

    always @(posedge clk)
    begin : monitor
        rsp_word_t exp_w;
        req_taken <= req_valid && !req_stall;
        cfg_taken <= cfg_valid && cfg_ready;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                age_limit = cfg_data;
            if (req_valid && !req_stall)
                reply_q.push_back(table_apply(req_word));
            if (rsp_valid && !rsp_stall)
            begin
                if (reply_q.size() == 0)
                begin
                    $error("reply word arrived with none expected");
                    fails++;
                end
                else
                begin
                    exp_w = reply_q.pop_front();
                    check_field("entry_count", exp_w.entry_count, rsp_word.entry_count);
                    check_field("found", exp_w.found, rsp_word.found);
                    check_field("slot", exp_w.slot, rsp_word.slot);
                    check_field("best_rssi", exp_w.best_rssi, rsp_word.best_rssi);
                    check_field("out_mac", exp_w.out_mac, rsp_word.out_mac);
                    check_field("out_mcs", exp_w.out_mcs, rsp_word.out_mcs);
                    check_field("out_rssi", exp_w.out_rssi, rsp_word.out_rssi);
                    check_field("out_snr", exp_w.out_snr, rsp_word.out_snr);
                    check_field("out_last_rx", exp_w.out_last_rx, rsp_word.out_last_rx);
                    check_field("out_bytes", exp_w.out_bytes, rsp_word.out_bytes);
                    check_field("out_packets", exp_w.out_packets, rsp_word.out_packets);
                end
            end
        end
    end

    always @(negedge clk)
    begin : req_driver
        if (rst_n && (!req_valid || req_taken))
        begin
            if (req_gap > 0)
            begin
                req_gap <= req_gap - 1;
                req_valid <= 1'b0;
            end
            else if (req_q.size() != 0)
            begin
                req_word <= req_q.pop_front();
                req_valid <= 1'b1;
                req_gap <= idle_length();
            end
            else
                req_valid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin : rsp_drain
        if (!rst_n || calm)
        begin
            rsp_stall <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left > 0)
        begin
            rsp_stall <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else
        begin
            rsp_stall <= 1'b0;
            if ($urandom_range(0, 99) < 25)
                stall_left <= idle_length();
        end
    end

    task automatic write_age_limit(input logic [30:0] v);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do
            @(negedge clk);
        while (!cfg_taken);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        while (req_q.size() != 0 || req_valid || reply_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic load_directed();
        // Empty table: read past the count, query with no entries, unused mode.
        req_q.push_back(make_word(MODE_READ, '0, '0, '0, '0, '0, '0, 4'd0));
        req_q.push_back(make_word(MODE_BEST_RSSI, '0, '0, '0, '0, '0, '0, 4'd0));
        req_q.push_back(make_word(MODE_UNUSED, '1, '1, -8'sd1, -8'sd1, '1, '1, '1));
        req_q.push_back(make_word(MODE_REGISTER, '0, 4'd0, -8'sd128, -8'sd128, '0, '0, 4'd0));
        req_q.push_back(make_word(MODE_REGISTER, '1, 4'hF, 8'sd127, 8'sd127, '1, '1, 4'd0));
        req_q.push_back(make_word(MODE_REGISTER, '0, 4'd5, 8'sd10, -8'sd20, '0, '1, 4'd0));
        req_q.push_back(make_word(MODE_READ, '0, '0, '0, '0, '0, '0, 4'd0));
        req_q.push_back(make_word(MODE_READ, '0, '0, '0, '0, '0, '0, 4'd15));
        // The all-ones entry lies in the future and still counts as recent.
        req_q.push_back(make_word(MODE_BEST_RSSI, '0, '0, '0, '0, 31'd5, '0, 4'd0));
        req_q.push_back(make_word(MODE_BEST_RSSI, '0, '0, '0, '0, '1, '0, 4'd0));
        for (int i = 2; i < ENTRIES; i++)
            req_q.push_back(make_word(MODE_REGISTER, mac_pool[i], 4'(i), 8'(i), -8'sd3,
                                      '0, 16'(i * 100), 4'd0));
        // Full table with a tie on the oldest time: the lowest slot is replaced.
        req_q.push_back(make_word(MODE_REGISTER, mac_pool[ENTRIES], 4'd9, 8'sd40, 8'sd4,
                                  31'd50, 16'd64, 4'd0));
    endtask

    initial
    begin : stimulus
        logic [30:0] limits [6];
        limits = '{31'd0, 31'h7FFF_FFFF, 31'd1, 31'd10, 31'd0, 31'd3};
        limits[4] = 31'($urandom());
        for (int i = 0; i < POOL; i++)
            mac_pool[i] = 48'({$urandom(), $urandom()});
        mac_pool[0] = '0;
        mac_pool[1] = '1;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        load_directed();
        wait_idle();
        for (int ph = 0; ph < 6; ph++)
        begin
            write_age_limit(limits[ph]);
            calm = (ph == 3);
            pool_span = (ph == 0) ? 6 : ((ph == 1) ? 12 : POOL);
            fresh_pct = (ph < 2) ? 1 : 10;
            clock_s = 31'($urandom_range(0, 1000));
            repeat (300) req_q.push_back(random_word());
            wait_idle();
        end
        repeat (30) @(posedge clk);
        if (fails == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin : watchdog
        #8000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
